### sv/command_frame_packer_macros.svh
// Assertion macros used by the command frame packer datapath
`ifndef COMMAND_FRAME_PACKER_MACROS_SVH
`define COMMAND_FRAME_PACKER_MACROS_SVH

// Clocked check with asynchronous reset masking
`define CFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen
`define CFP_NEVER(lbl, cond, msg) \
	`CFP_ASSERT(lbl, !(cond), msg)

`endif

### sv/cfp_pkg.sv
// Types and constants of the command frame packer
`default_nettype none
package cfp_pkg;

	localparam logic [4:0] MAX_PAYLOAD = 5'd16;
	localparam int PAY_W = 128;
	localparam int PIDX_W = 4;

	localparam logic [0:0] REG_HEADER   = 1'd0;
	localparam logic [0:0] REG_REQ_TYPE = 1'd1;

	localparam logic [7:0] HEADER_RESET   = 8'hAA;
	localparam logic [7:0] REQ_TYPE_RESET = 8'h01;
	localparam logic [7:0] SEQ_RESET      = 8'h01;

	typedef struct packed {
		logic [7:0]  frame_type;
		logic [7:0]  command_code;
		logic [7:0]  axis_number;
		logic [4:0]  payload_len;
		logic [63:0] payload_low;
		logic [63:0] payload_high;
	} cfp_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} cfp_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HDR, ST_TYPE, ST_CMD, ST_AXIS, ST_SEQ, ST_LEN, ST_PAY, ST_CRC
	} cfp_state_t;

	typedef enum logic [2:0] {
		SEL_HDR, SEL_TYPE, SEL_CMD, SEL_AXIS, SEL_SEQ, SEL_LEN, SEL_PAY, SEL_CRC
	} cfp_sel_t;

	typedef struct packed {
		logic     capture;
		logic     emit;
		cfp_sel_t sel;
	} cfp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic len_zero;
		logic pay_last;
	} cfp_stat_t;

endpackage
`default_nettype wire

### sv/command_frame_packer.sv
// Top level of the command frame packer
`default_nettype none
// Takes one command beat and sends it as a frame of 7 + min(payload_len, 16) byte beats:
// header, type, command, axis, sequence number, length, payload bytes, then the XOR of
// all bytes before it (flagged with last_byte). The frame sequencer emits one byte per
// cycle while the output register is free, and a new command is taken in the cycle
// after a frame's checksum byte has been loaded. The sequence number starts at 1 and
// advances after each frame whose type matches request_type_code, going from 255 to 1.
// Register 0 is header_byte (reset 0xAA), register 1 request_type_code (reset 0x01).
module command_frame_packer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cfp_pkg::cfp_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cfp_pkg::cfp_out_t      out_data,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [7:0]        cfg_wdata
);

	cfp_pkg::cfp_cmd_t  cmd;
	cfp_pkg::cfp_stat_t stat;

	cfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cfp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

### sv/cfp_ctrl.sv
// Frame sequencing state machine of the command frame packer
`default_nettype none
module cfp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cfp_pkg::cfp_stat_t stat,
	output cfp_pkg::cfp_cmd_t       cmd
);

	cfp_pkg::cfp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.emit    = 1'b0;
		cmd.sel     = cfp_pkg::SEL_HDR;
		unique case (state_q)
			cfp_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) state_d = cfp_pkg::ST_HDR;
			end
			cfp_pkg::ST_HDR: begin
				cmd.sel  = cfp_pkg::SEL_HDR;
				cmd.emit = stat.out_free;
				if (stat.out_free) state_d = cfp_pkg::ST_TYPE;
			end
			cfp_pkg::ST_TYPE: begin
				cmd.sel  = cfp_pkg::SEL_TYPE;
				cmd.emit = stat.out_free;
				if (stat.out_free) state_d = cfp_pkg::ST_CMD;
			end
			cfp_pkg::ST_CMD: begin
				cmd.sel  = cfp_pkg::SEL_CMD;
				cmd.emit = stat.out_free;
				if (stat.out_free) state_d = cfp_pkg::ST_AXIS;
			end
			cfp_pkg::ST_AXIS: begin
				cmd.sel  = cfp_pkg::SEL_AXIS;
				cmd.emit = stat.out_free;
				if (stat.out_free) state_d = cfp_pkg::ST_SEQ;
			end
			cfp_pkg::ST_SEQ: begin
				cmd.sel  = cfp_pkg::SEL_SEQ;
				cmd.emit = stat.out_free;
				if (stat.out_free) state_d = cfp_pkg::ST_LEN;
			end
			cfp_pkg::ST_LEN: begin
				cmd.sel  = cfp_pkg::SEL_LEN;
				cmd.emit = stat.out_free;
				// skip the payload phase on an empty command
				if (stat.out_free) state_d = stat.len_zero ? cfp_pkg::ST_CRC : cfp_pkg::ST_PAY;
			end
			cfp_pkg::ST_PAY: begin
				cmd.sel  = cfp_pkg::SEL_PAY;
				cmd.emit = stat.out_free;
				if (stat.out_free && stat.pay_last) state_d = cfp_pkg::ST_CRC;
			end
			cfp_pkg::ST_CRC: begin
				cmd.sel  = cfp_pkg::SEL_CRC;
				cmd.emit = stat.out_free;
				if (stat.out_free) state_d = cfp_pkg::ST_IDLE;
			end
			default: state_d = cfp_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### sv/cfp_datapath.sv
// Field registers, byte select, checksum, sequence counter and output register
`default_nettype none
`include "command_frame_packer_macros.svh"
module cfp_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfp_pkg::cfp_in_t in_data,
	input  wire cfp_pkg::cfp_cmd_t cmd,
	output cfp_pkg::cfp_stat_t    stat,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [7:0]       cfg_wdata,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output cfp_pkg::cfp_out_t     out_data
);

	logic [7:0]                   header_q, req_type_q, seq_q;
	logic [7:0]                   type_q, code_q, axis_q, crc_q;
	logic [4:0]                   len_q;
	logic [cfp_pkg::PAY_W-1:0]    pay_q;
	logic [cfp_pkg::PIDX_W-1:0]   pidx_q;
	logic                         out_valid_q;
	cfp_pkg::cfp_out_t            out_q;
	logic [7:0]                   byte_d;
	logic [4:0]                   len_sat;

	assign len_sat = (in_data.payload_len > cfp_pkg::MAX_PAYLOAD) ? cfp_pkg::MAX_PAYLOAD
		: in_data.payload_len;

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.len_zero = (len_q == 5'd0);
	assign stat.pay_last = (({1'b0, pidx_q} + 5'd1) == len_q);

	always_comb begin
		case (cmd.sel)
			cfp_pkg::SEL_HDR:  byte_d = header_q;
			cfp_pkg::SEL_TYPE: byte_d = type_q;
			cfp_pkg::SEL_CMD:  byte_d = code_q;
			cfp_pkg::SEL_AXIS: byte_d = axis_q;
			cfp_pkg::SEL_SEQ:  byte_d = seq_q;
			cfp_pkg::SEL_LEN:  byte_d = {3'd0, len_q};
			cfp_pkg::SEL_PAY:  byte_d = pay_q[7:0];
			cfp_pkg::SEL_CRC:  byte_d = crc_q;
			default:           byte_d = crc_q;
		endcase
	end

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q    <= cfp_pkg::HEADER_RESET;
			req_type_q  <= cfp_pkg::REQ_TYPE_RESET;
			seq_q       <= cfp_pkg::SEQ_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cfp_pkg::REG_HEADER:   header_q   <= cfg_wdata;
					cfp_pkg::REG_REQ_TYPE: req_type_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// advance after a request frame, skipping zero on wrap
			if (cmd.emit && cmd.sel == cfp_pkg::SEL_CRC && type_q == req_type_q) begin
				seq_q <= (seq_q == 8'hFF) ? 8'd1 : seq_q + 8'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q <= in_data.frame_type;
			code_q <= in_data.command_code;
			axis_q <= in_data.axis_number;
			len_q  <= len_sat;
			pay_q  <= {in_data.payload_high, in_data.payload_low};
			pidx_q <= '0;
			crc_q  <= 8'd0;
		end else if (cmd.emit) begin
			crc_q <= crc_q ^ byte_d;
			if (cmd.sel == cfp_pkg::SEL_PAY) begin
				pay_q  <= pay_q >> 8;
				pidx_q <= pidx_q + 4'd1;
			end
		end
		if (cmd.emit) begin
			out_q.frame_byte <= byte_d;
			out_q.last_byte  <= (cmd.sel == cfp_pkg::SEL_CRC);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CFP_NEVER(a_seq_nonzero, seq_q == 8'd0, "sequence counter reached zero")
	`CFP_ASSERT(a_pay_in_range, (cmd.emit && cmd.sel == cfp_pkg::SEL_PAY) |-> ({1'b0, pidx_q} < len_q), "payload beat beyond length")
	`CFP_ASSERT(a_seq_at_crc, (seq_q != $past(seq_q)) |-> $past(cmd.emit && cmd.sel == cfp_pkg::SEL_CRC), "sequence moved outside checksum beat")

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the command frame packer: directed table, random frames, short request run
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_AT_FRAME  = 70;

	typedef struct {
		bit         known;
		logic [7:0] crc;
	} crc_note_t;

	typedef struct {
		cfp_pkg::cfp_in_t cmd;
		bit               known;
		logic [7:0]       crc;
	} dir_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	cfp_pkg::cfp_in_t  in_data   = '0;
	logic              out_ready = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [0:0]        cfg_index = cfp_pkg::REG_HEADER;
	logic [7:0]        cfg_wdata = 8'h00;
	logic              in_ready;
	logic              out_valid;
	cfp_pkg::cfp_out_t out_data;

	// frame model state and expected byte beats
	logic [7:0]        hdr_m = cfp_pkg::HEADER_RESET;
	logic [7:0]        req_m = cfp_pkg::REQ_TYPE_RESET;
	logic [7:0]        seq_m = cfp_pkg::SEQ_RESET;
	cfp_pkg::cfp_out_t frame_q[$];
	crc_note_t         crc_note_q[$];
	dir_row_t          dir_tab[$];

	int  errors     = 0;
	int  frames_in  = 0;
	int  bytes_out  = 0;
	int  sat_frames = 0;
	int  idle_cnt   = 0;
	int  burst_left = 0;
	bit  holding    = 1'b0;
	bit  hold_done  = 1'b0;

	always #4 clk = ~clk;

	command_frame_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	task automatic report(input string msg);
		errors++;
		if (errors <= 50)
			$display("MISMATCH at %0t ns: %s", $realtime, msg);
	endtask

	function automatic void push_byte(input logic [7:0] v, inout logic [7:0] crc);
		frame_q.push_back('{frame_byte: v, last_byte: 1'b0});
		crc ^= v;
	endfunction

	function automatic void pack_frame(input cfp_pkg::cfp_in_t c, input crc_note_t note);
		logic [4:0]   n;
		logic [127:0] pay;
		logic [7:0]   crc;
		n = (c.payload_len > cfp_pkg::MAX_PAYLOAD) ? cfp_pkg::MAX_PAYLOAD : c.payload_len;
		if (c.payload_len > cfp_pkg::MAX_PAYLOAD)
			sat_frames++;
		pay = {c.payload_high, c.payload_low};
		crc = 8'h00;
		push_byte(hdr_m, crc);
		push_byte(c.frame_type, crc);
		push_byte(c.command_code, crc);
		push_byte(c.axis_number, crc);
		push_byte(seq_m, crc);
		push_byte({3'b000, n}, crc);
		for (int i = 0; i < n; i++)
			push_byte(pay[8*i +: 8], crc);
		frame_q.push_back('{frame_byte: note.known ? note.crc : crc, last_byte: 1'b1});
		// advance after the frame, skip zero on wrap
		if (c.frame_type == req_m) begin
			seq_m = seq_m + 8'd1;
			if (seq_m == 8'h00)
				seq_m = 8'h01;
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: pick_byte = 8'h00;
			1: pick_byte = 8'hFF;
			default: pick_byte = 8'($urandom);
		endcase
	endfunction

	function automatic cfp_pkg::cfp_in_t rand_cmd(input int req_pct, input int max_len);
		cfp_pkg::cfp_in_t c;
		c.frame_type   = ($urandom_range(0, 99) < req_pct) ? req_m : pick_byte();
		c.command_code = pick_byte();
		c.axis_number  = pick_byte();
		if (max_len == cfp_pkg::MAX_PAYLOAD && $urandom_range(0, 9) == 0)
			c.payload_len = 5'($urandom_range(17, 31));
		else
			c.payload_len = 5'($urandom_range(0, max_len));
		c.payload_low  = {$urandom, $urandom};
		c.payload_high = {$urandom, $urandom};
		return c;
	endfunction

	function automatic void dir_row(input logic [7:0] ty, input logic [7:0] cm,
			input logic [7:0] ax, input logic [4:0] ln, input logic [63:0] lo,
			input logic [63:0] hi, input bit known, input logic [7:0] crc);
		dir_row_t r;
		r.cmd   = '{frame_type: ty, command_code: cm, axis_number: ax, payload_len: ln,
			payload_low: lo, payload_high: hi};
		r.known = known;
		r.crc   = crc;
		dir_tab.push_back(r);
	endfunction

	// Sender pacing: bursts of beats separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = holding ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
	endtask

	task automatic send_cmd(input cfp_pkg::cfp_in_t c, input crc_note_t note);
		crc_note_q.push_back(note);
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] h, input logic [7:0] r);
		cfg_we    <= 1'b1;
		cfg_index <= cfp_pkg::REG_HEADER;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_index <= cfp_pkg::REG_REQ_TYPE;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr_m = h;
		req_m = r;
	endtask

	task automatic random_phase(input int count, input int req_pct, input int max_len);
		crc_note_t none;
		none = '{known: 1'b0, crc: 8'h00};
		for (int i = 0; i < count; i++) begin
			if (!holding && $urandom_range(0, 14) == 0)
				drain();
			pace();
			send_cmd(rand_cmd(req_pct, max_len), none);
		end
		drain();
	endtask

	// Scoreboard on accepted beats
	always @(posedge clk) begin
		cfp_pkg::cfp_out_t want;
		crc_note_t         note;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				bytes_out++;
				if (frame_q.size() == 0) begin
					report($sformatf("byte beat 0x%02h last=%0b with no frame pending",
						out_data.frame_byte, out_data.last_byte));
				end else begin
					want = frame_q.pop_front();
					if (out_data.frame_byte !== want.frame_byte)
						report($sformatf("frame_byte 0x%02h, expected 0x%02h",
							out_data.frame_byte, want.frame_byte));
					if (out_data.last_byte !== want.last_byte)
						report($sformatf("last_byte %0b, expected %0b",
							out_data.last_byte, want.last_byte));
				end
			end
			if (in_valid && in_ready) begin
				note = (crc_note_q.size() != 0) ? crc_note_q.pop_front()
					: crc_note_t'{1'b0, 8'h00};
				pack_frame(in_data, note);
				frames_in++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat accepted for %0d cycles", idle_cnt);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Receiver: stall patterns of its own, one long hold-off to back up the input
	initial begin
		int mode;
		int n;
		wait (arst_n);
		forever begin
			if (!hold_done && frames_in >= HOLD_AT_FRAME) begin
				hold_done = 1'b1;
				holding   = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holding = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				n    = $urandom_range(4, 40);
				repeat (n) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= ($urandom_range(0, 99) < 60);
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ~out_ready;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [63:0] r0;
		logic [63:0] r1;
		r0 = {$urandom, $urandom};
		r1 = {$urandom, $urandom};
		// typed checksums follow from reset values: header 0xAA, request type 1, sequence 1
		dir_row(8'h00, 8'h00, 8'h00, 5'd0,  '0, '0, 1'b1, 8'hAB);
		dir_row(8'hFF, 8'hFF, 8'hFF, 5'd0,  '0, '0, 1'b1, 8'h54);
		dir_row(8'h01, 8'h00, 8'h00, 5'd0,  '0, '0, 1'b1, 8'hAA);
		dir_row(8'h00, 8'h00, 8'h00, 5'd16, '1, '1, 1'b1, 8'hB8);
		dir_row(8'h00, 8'h00, 8'h00, 5'd31, '0, '0, 1'b1, 8'hB8);
		dir_row(8'h12, 8'h34, 8'h01, 5'd1,  r0, r1, 1'b0, 8'h00);
		dir_row(8'h02, 8'h80, 8'h7F, 5'd7,  r0, r1, 1'b0, 8'h00);
		dir_row(8'h01, 8'h55, 8'h02, 5'd8,  r0, r1, 1'b0, 8'h00);
		dir_row(8'h03, 8'hAA, 8'h03, 5'd9,  r0, r1, 1'b0, 8'h00);
		dir_row(8'h01, 8'h0F, 8'hF0, 5'd15, r1, r0, 1'b0, 8'h00);
		dir_row(8'h00, 8'hFF, 8'h00, 5'd17, r0, r1, 1'b0, 8'h00);
		dir_row(8'h01, 8'h01, 8'h01, 5'd0,  '1, '1, 1'b0, 8'h00);
		dir_row(8'hFE, 8'h00, 8'hFF, 5'd3,  '1, '1, 1'b0, 8'h00);
		dir_row(8'h01, 8'hC3, 8'h00, 5'd16, r0, r1, 1'b0, 8'h00);
		dir_row(8'h01, 8'hFF, 8'h00, 5'd5,  r1, r0, 1'b0, 8'h00);
		dir_row(8'h80, 8'h3C, 8'h00, 5'd2,  r0, r1, 1'b0, 8'h00);
		dir_row(8'h7F, 8'h00, 8'h10, 5'd20, r1, r0, 1'b0, 8'h00);
		dir_row(8'h01, 8'h99, 8'h66, 5'd16, '0, '1, 1'b0, 8'h00);
		dir_row(8'h00, 8'h00, 8'h00, 5'd16, '1, '0, 1'b0, 8'h00);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			pace();
			send_cmd(dir_tab[i].cmd, '{known: dir_tab[i].known, crc: dir_tab[i].crc});
		end
		drain();

		set_regs(8'h00, 8'hFF);
		random_phase(30, 30, cfp_pkg::MAX_PAYLOAD);
		set_regs(8'hFF, 8'h00);
		random_phase(30, 30, cfp_pkg::MAX_PAYLOAD);
		set_regs(8'($urandom), 8'($urandom));
		random_phase(30, 30, cfp_pkg::MAX_PAYLOAD);
		// request frames only with short payloads: every frame advances the counter
		set_regs(8'($urandom), 8'($urandom));
		random_phase(21, 100, 2);

		repeat (20) @(posedge clk);
		$display("Covered %0d frames in %0d byte beats, %0d with saturated length",
			frames_in, bytes_out, sat_frames);
		$display("Register settings: reset, 00/FF, FF/00, two random pairs; %0d-cycle hold-off",
			LONG_HOLD);
		if (errors == 0 && frame_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (frame_q.size() != 0)
				$display("%0d expected byte beats never arrived", frame_q.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/cfp_pkg.sv
sv/cfp_ctrl.sv
sv/cfp_datapath.sv
sv/command_frame_packer.sv
tb/testbench.sv
